[hdl/iir_df2_pkg.sv]
// ----------------------------------------------------------------------------
// IIR direct-form-II filter package
// Shared widths, codes and control structures of the filter block.
// ----------------------------------------------------------------------------
package iir_df2_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int DELAY_W    = 32;
    localparam int PROD_W     = COEF_W + DELAY_W;
    localparam int CMD_W      = 2;
    localparam int CIDX_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 8192;

    localparam logic [COUNT_W-1:0]         COUNT_RESET   = 4'd1;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN_RESET = -16'sd25600;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX_RESET = 16'sd25600;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER = 2'd0,
        CMD_WR_NUM = 2'd1,
        CMD_WR_FB  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COUNT = 2'd0,
        CFG_DEN_COUNT = 2'd1,
        CFG_SAT_MIN   = 2'd2,
        CFG_SAT_MAX   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_FB_DRAIN,
        ST_FF,
        ST_TAP0,
        ST_FF_DRAIN
    } state_t;

    typedef struct packed {
        logic valid;
        logic acc;
        logic sub;
        logic wr;
        logic node;
    } op_t;

    typedef struct packed {
        logic load_input;
        logic make_node;
        logic prod_en;
        logic use_node;
        logic acc_en;
        logic acc_sub;
    } mac_ctl_t;

endpackage

[hdl/iir_df2_item_if.sv]
// ----------------------------------------------------------------------------
// IIR filter item channel
// Valid/ready channel that carries commands and samples into the filter.
// ----------------------------------------------------------------------------
interface iir_df2_item_if;
    import iir_df2_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (output valid, output cmd, output sample_in, output coef_index,
                    output coef_value, input ready);
    modport sink (input valid, input cmd, input sample_in, input coef_index,
                  input coef_value, output ready);
endinterface

[hdl/iir_df2_result_if.sv]
// ----------------------------------------------------------------------------
// IIR filter result channel
// Valid/ready channel that carries filtered samples out of the filter.
// ----------------------------------------------------------------------------
interface iir_df2_result_if;
    import iir_df2_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clamped;

    modport source (output valid, output sample_out, output clamped, input ready);
    modport sink (input valid, input sample_out, input clamped, output ready);
endinterface

[hdl/iir_df2_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module iir_df2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[hdl/iir_df2_store.sv]
// ----------------------------------------------------------------------------
// IIR filter state store
// Coefficient and delay-line memories; entries never written read as zero.
// ----------------------------------------------------------------------------
module iir_df2_store #(
    parameter int TAPS = 8,
    localparam int IDX_W = $clog2(TAPS),
    localparam int CA_W = IDX_W + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    coef_we,
    input  logic [CA_W-1:0]                         coef_waddr,
    input  logic signed [iir_df2_pkg::COEF_W-1:0]   coef_wdata,
    input  logic [CA_W-1:0]                         coef_raddr,
    output logic signed [iir_df2_pkg::COEF_W-1:0]   coef_rdata,
    input  logic                                    delay_we,
    input  logic [IDX_W-1:0]                        delay_waddr,
    input  logic signed [iir_df2_pkg::DELAY_W-1:0]  delay_wdata,
    input  logic [IDX_W-1:0]                        delay_raddr,
    output logic signed [iir_df2_pkg::DELAY_W-1:0]  delay_rdata
);
    import iir_df2_pkg::*;

    localparam int CDEPTH = 1 << CA_W;

    logic [CDEPTH-1:0]  coef_vld_reg;
    logic [CDEPTH-1:0]  coef_vld_next;
    logic [TAPS-1:0]    delay_vld_reg;
    logic [TAPS-1:0]    delay_vld_next;
    logic               coef_rv_reg;
    logic               delay_rv_reg;
    logic [COEF_W-1:0]  coef_q;
    logic [DELAY_W-1:0] delay_q;

    iir_df2_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_q)
    );

    iir_df2_ram #(.WIDTH(DELAY_W), .DEPTH(TAPS)) u_delay_ram (
        .clk   (clk),
        .we    (delay_we),
        .waddr (delay_waddr),
        .wdata (delay_wdata),
        .raddr (delay_raddr),
        .rdata (delay_q)
    );

    always_comb
    begin
        coef_vld_next  = coef_vld_reg;
        delay_vld_next = delay_vld_reg;
        if (coef_we)
        begin
            coef_vld_next[coef_waddr] = 1'b1;
        end
        if (delay_we)
        begin
            delay_vld_next[delay_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg  <= '0;
            delay_vld_reg <= '0;
            coef_rv_reg   <= 1'b0;
            delay_rv_reg  <= 1'b0;
        end
        else
        begin
            coef_vld_reg  <= coef_vld_next;
            delay_vld_reg <= delay_vld_next;
            coef_rv_reg   <= coef_vld_reg[coef_raddr];
            delay_rv_reg  <= delay_vld_reg[delay_raddr];
        end
    end

    assign coef_rdata  = coef_rv_reg ? signed'(coef_q) : '0;
    assign delay_rdata = delay_rv_reg ? signed'(delay_q) : '0;
endmodule

[hdl/iir_df2_mac.sv]
// ----------------------------------------------------------------------------
// IIR filter multiply-accumulate unit
// Shared multiplier and accumulator, node saturation and output clamp.
// ----------------------------------------------------------------------------
module iir_df2_mac #(
    parameter int TAPS = 8
) (
    input  logic                                    clk,
    input  iir_df2_pkg::mac_ctl_t                   ctl,
    input  logic signed [iir_df2_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [iir_df2_pkg::COEF_W-1:0]   coef_rd,
    input  logic signed [iir_df2_pkg::DELAY_W-1:0]  delay_rd,
    input  logic signed [iir_df2_pkg::SAMPLE_W-1:0] sat_min,
    input  logic signed [iir_df2_pkg::SAMPLE_W-1:0] sat_max,
    output logic signed [iir_df2_pkg::DELAY_W-1:0]  shift_data,
    output logic signed [iir_df2_pkg::SAMPLE_W-1:0] y_value,
    output logic                                    y_clamped
);
    import iir_df2_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(TAPS) + 2;

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [DELAY_W-1:0] node_reg;
    logic signed [DELAY_W-1:0] node_next;
    logic signed [DELAY_W-1:0] node_sat;
    logic signed [ACC_W-1:0]   rounded;
    logic [ACC_W-DELAY_W:0]    upper;
    logic signed [ACC_W-1:0]   lo_lim;
    logic signed [ACC_W-1:0]   hi_lim;
    logic signed [ACC_W-1:0]   lo_done;
    logic signed [ACC_W-1:0]   hi_done;
    logic                      lo_hit;
    logic                      hi_hit;

    always_comb
    begin
        shift_data = ctl.use_node ? node_reg : delay_rd;
        prod_next  = coef_rd * shift_data;
        rounded    = (acc_reg + ACC_W'(ROUND_BIAS)) >>> FRAC_SHIFT;

        upper = rounded[ACC_W-1:DELAY_W-1];
        if ((&upper) || !(|upper))
        begin
            node_sat = rounded[DELAY_W-1:0];
        end
        else if (rounded[ACC_W-1])
        begin
            node_sat = {1'b1, {(DELAY_W-1){1'b0}}};
        end
        else
        begin
            node_sat = {1'b0, {(DELAY_W-1){1'b1}}};
        end
        node_next = ctl.make_node ? node_sat : node_reg;

        if (ctl.load_input)
        begin
            acc_next = ACC_W'(sample) <<< FRAC_SHIFT;
        end
        else if (ctl.make_node)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = ctl.acc_sub ? (acc_reg - ACC_W'(prod_reg))
                                   : (acc_reg + ACC_W'(prod_reg));
        end
        else
        begin
            acc_next = acc_reg;
        end

        // The lower limit is applied first, so the upper one wins when they cross.
        lo_lim    = ACC_W'(sat_min);
        hi_lim    = ACC_W'(sat_max);
        lo_hit    = rounded < lo_lim;
        lo_done   = lo_hit ? lo_lim : rounded;
        hi_hit    = lo_done > hi_lim;
        hi_done   = hi_hit ? hi_lim : lo_done;
        y_value   = hi_done[SAMPLE_W-1:0];
        y_clamped = lo_hit | hi_hit;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        node_reg <= node_next;
        if (ctl.prod_en)
        begin
            prod_reg <= prod_next;
        end
    end
endmodule

[hdl/iir_df2_ctrl.sv]
// ----------------------------------------------------------------------------
// IIR filter sequencer
// Accepts beats, walks the feedback and feed-forward taps through the
// memories and steers the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module iir_df2_ctrl #(
    parameter int TAPS = 8,
    localparam int IDX_W = $clog2(TAPS),
    localparam int CA_W = IDX_W + 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic [iir_df2_pkg::CMD_W-1:0]         item_cmd,
    input  logic [iir_df2_pkg::CIDX_W-1:0]        item_coef_index,
    input  logic [iir_df2_pkg::COUNT_W-1:0]       num_count,
    input  logic [iir_df2_pkg::COUNT_W-1:0]       den_count,
    input  logic                                  out_free,
    output logic                                  result_load,
    output iir_df2_pkg::mac_ctl_t                 mac_ctl,
    output logic                                  coef_we,
    output logic [CA_W-1:0]                       coef_waddr,
    output logic [CA_W-1:0]                       coef_raddr,
    output logic                                  delay_we,
    output logic [IDX_W-1:0]                      delay_waddr,
    output logic [IDX_W-1:0]                      delay_raddr
);
    import iir_df2_pkg::*;

    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int EW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    function automatic logic [CNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
        logic [EW-1:0] cw;
        cw = EW'(c);
        if (c == '0)
        begin
            return CNT_W'(1);
        end
        if (cw > EW'(TAPS))
        begin
            return CNT_W'(TAPS);
        end
        return CNT_W'(cw);
    endfunction

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    op_t               op_d_reg;
    op_t               op_a_reg;
    op_t               issue_op;
    logic [IDX_W-1:0]  waddr_d_reg;
    logic [IDX_W-1:0]  issue_waddr;
    logic [CNT_W-1:0]  na;
    logic [CNT_W-1:0]  nb;
    logic [CNT_W-1:0]  n;
    logic [IDX_W-1:0]  na_last;
    logic [IDX_W-1:0]  n_last;
    logic              accept;
    logic              busy;
    logic              idx_ok;
    logic              load_input;
    logic              make_node;

    assign na      = eff_count(den_count);
    assign nb      = eff_count(num_count);
    assign n       = (na > nb) ? na : nb;
    assign na_last = IDX_W'(na - CNT_W'(1));
    assign n_last  = IDX_W'(n - CNT_W'(1));
    assign accept  = item_valid && item_ready;
    assign busy    = op_d_reg.valid || op_a_reg.valid;
    assign idx_ok  = 32'(item_coef_index) < 32'(TAPS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item_cmd == CMD_FILTER))
                begin
                    state_next = (na > CNT_W'(1)) ? ST_FB : ST_FB_DRAIN;
                end
            end
            ST_FB:
            begin
                if (cnt_reg == na_last)
                begin
                    state_next = ST_FB_DRAIN;
                end
            end
            ST_FB_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = (n > CNT_W'(1)) ? ST_FF : ST_TAP0;
                end
            end
            ST_FF:
            begin
                if (cnt_reg == IDX_W'(1))
                begin
                    state_next = ST_TAP0;
                end
            end
            ST_TAP0:
            begin
                state_next = ST_FF_DRAIN;
            end
            ST_FF_DRAIN:
            begin
                if (!busy && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready  = 1'b0;
        cnt_next    = cnt_reg;
        issue_op    = '0;
        issue_waddr = '0;
        coef_we     = 1'b0;
        coef_waddr  = {(item_cmd == CMD_WR_FB), IDX_W'(item_coef_index)};
        coef_raddr  = {1'b0, cnt_reg};
        delay_raddr = cnt_reg - IDX_W'(1);
        load_input  = 1'b0;
        make_node   = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    case (item_cmd)
                        CMD_FILTER:
                        begin
                            load_input = 1'b1;
                            cnt_next   = IDX_W'(1);
                        end
                        CMD_WR_NUM:
                        begin
                            coef_we = idx_ok;
                        end
                        CMD_WR_FB:
                        begin
                            coef_we = idx_ok && (item_coef_index != '0);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FB:
            begin
                coef_raddr = {1'b1, cnt_reg};
                issue_op   = '{valid: 1'b1, acc: 1'b1, sub: 1'b1, wr: 1'b0, node: 1'b0};
                cnt_next   = cnt_reg + IDX_W'(1);
            end
            ST_FB_DRAIN:
            begin
                if (!busy)
                begin
                    make_node = 1'b1;
                    cnt_next  = n_last;
                end
            end
            ST_FF:
            begin
                issue_op    = '{valid: 1'b1, acc: (CNT_W'(cnt_reg) < nb), sub: 1'b0,
                                wr: 1'b1, node: 1'b0};
                issue_waddr = cnt_reg;
                cnt_next    = cnt_reg - IDX_W'(1);
            end
            ST_TAP0:
            begin
                coef_raddr = '0;
                issue_op   = '{valid: 1'b1, acc: 1'b1, sub: 1'b0, wr: 1'b1, node: 1'b1};
            end
            ST_FF_DRAIN:
            begin
                result_load = !busy && out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            op_d_reg    <= '0;
            op_a_reg    <= '0;
            waddr_d_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            op_d_reg    <= issue_op;
            op_a_reg    <= op_d_reg;
            waddr_d_reg <= issue_waddr;
        end
    end

    assign delay_we    = op_d_reg.valid && op_d_reg.wr;
    assign delay_waddr = waddr_d_reg;

    assign mac_ctl.load_input = load_input;
    assign mac_ctl.make_node  = make_node;
    assign mac_ctl.prod_en    = op_d_reg.valid && op_d_reg.acc;
    assign mac_ctl.use_node   = op_d_reg.node;
    assign mac_ctl.acc_en     = op_a_reg.valid && op_a_reg.acc;
    assign mac_ctl.acc_sub    = op_a_reg.sub;
endmodule

[hdl/iir_direct_form2_filter_top.sv]
// ----------------------------------------------------------------------------
// IIR direct-form-II filter
// Fixed-point filter with coefficients and delay line held in RAM and one
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// item      in   cmd, sample_in, coef_index, coef_value
// result    out  sample_out, clamped (one beat per filter command)
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// A coefficient beat is written as it is taken. A filter beat walks the
// na - 1 feedback taps and then the n feed-forward taps one at a time,
// where na and n are the effective denominator and overall tap counts; the
// single multiplier and the one read port of each memory set that pace.
// After reset the memories read as zero through per-entry valid bits, so
// there is no clearing pass. A result waits in the output register; only
// the final step of the next filter beat stalls behind an untaken result.
// ----------------------------------------------------------------------------
module iir_direct_form2_filter_top #(
    parameter int TAPS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    iir_df2_item_if.sink                           item,
    iir_df2_result_if.source                       result,
    input  logic                                   cfg_we,
    input  logic [iir_df2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iir_df2_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import iir_df2_pkg::*;

    localparam int IDX_W = $clog2(TAPS);
    localparam int CA_W = IDX_W + 1;

    logic [COUNT_W-1:0]         num_count_reg;
    logic [COUNT_W-1:0]         num_count_next;
    logic [COUNT_W-1:0]         den_count_reg;
    logic [COUNT_W-1:0]         den_count_next;
    logic signed [SAMPLE_W-1:0] sat_min_reg;
    logic signed [SAMPLE_W-1:0] sat_min_next;
    logic signed [SAMPLE_W-1:0] sat_max_reg;
    logic signed [SAMPLE_W-1:0] sat_max_next;

    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       clamped_reg;
    logic                       out_free;
    logic                       result_load;

    mac_ctl_t                   mac_ctl;
    logic                       coef_we;
    logic [CA_W-1:0]            coef_waddr;
    logic [CA_W-1:0]            coef_raddr;
    logic signed [COEF_W-1:0]   coef_rdata;
    logic                       delay_we;
    logic [IDX_W-1:0]           delay_waddr;
    logic [IDX_W-1:0]           delay_raddr;
    logic signed [DELAY_W-1:0]  delay_rdata;
    logic signed [DELAY_W-1:0]  shift_data;
    logic signed [SAMPLE_W-1:0] y_value;
    logic                       y_clamped;

    always_comb
    begin
        num_count_next = num_count_reg;
        den_count_next = den_count_reg;
        sat_min_next   = sat_min_reg;
        sat_max_next   = sat_max_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_COUNT: num_count_next = cfg_data[COUNT_W-1:0];
                CFG_DEN_COUNT: den_count_next = cfg_data[COUNT_W-1:0];
                CFG_SAT_MIN:   sat_min_next   = signed'(cfg_data[SAMPLE_W-1:0]);
                CFG_SAT_MAX:   sat_max_next   = signed'(cfg_data[SAMPLE_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_count_reg <= COUNT_RESET;
            den_count_reg <= COUNT_RESET;
            sat_min_reg   <= SAT_MIN_RESET;
            sat_max_reg   <= SAT_MAX_RESET;
        end
        else
        begin
            num_count_reg <= num_count_next;
            den_count_reg <= den_count_next;
            sat_min_reg   <= sat_min_next;
            sat_max_reg   <= sat_max_next;
        end
    end

    iir_df2_ctrl #(.TAPS(TAPS)) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item.valid),
        .item_ready      (item.ready),
        .item_cmd        (item.cmd),
        .item_coef_index (item.coef_index),
        .num_count       (num_count_reg),
        .den_count       (den_count_reg),
        .out_free        (out_free),
        .result_load     (result_load),
        .mac_ctl         (mac_ctl),
        .coef_we         (coef_we),
        .coef_waddr      (coef_waddr),
        .coef_raddr      (coef_raddr),
        .delay_we        (delay_we),
        .delay_waddr     (delay_waddr),
        .delay_raddr     (delay_raddr)
    );

    iir_df2_store #(.TAPS(TAPS)) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef_we     (coef_we),
        .coef_waddr  (coef_waddr),
        .coef_wdata  (item.coef_value),
        .coef_raddr  (coef_raddr),
        .coef_rdata  (coef_rdata),
        .delay_we    (delay_we),
        .delay_waddr (delay_waddr),
        .delay_wdata (shift_data),
        .delay_raddr (delay_raddr),
        .delay_rdata (delay_rdata)
    );

    iir_df2_mac #(.TAPS(TAPS)) u_mac (
        .clk        (clk),
        .ctl        (mac_ctl),
        .sample     (item.sample_in),
        .coef_rd    (coef_rdata),
        .delay_rd   (delay_rdata),
        .sat_min    (sat_min_reg),
        .sat_max    (sat_max_reg),
        .shift_data (shift_data),
        .y_value    (y_value),
        .y_clamped  (y_clamped)
    );

    assign out_free = !result_valid_reg || result.ready;

    always_comb
    begin
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            sample_out_reg <= y_value;
            clamped_reg    <= y_clamped;
        end
    end

    assign result.valid      = result_valid_reg;
    assign result.sample_out = sample_out_reg;
    assign result.clamped    = clamped_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (!result_valid_reg || result.ready))
        else $error("Result loaded over a beat that was not taken.");

    a_filter_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.cmd == CMD_FILTER)) |=> !item.ready)
        else $error("Input accepted while a filter beat is in progress.");

    a_idle_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !delay_we)
        else $error("Delay line written while the filter is idle.");
endmodule
